### hdl/pidc_pkg.sv
// Shared types and constants for the incremental PID speed controller.
`default_nettype none

package pidc_pkg;

	localparam int GAIN_W = 32;
	localparam int OUT_W  = 15;
	localparam int ACC_W  = 48;
	localparam int SUM_W  = 50;

	localparam logic [GAIN_W-1:0] P_GAIN_RST     = 32'd20635976;
	localparam logic [GAIN_W-1:0] I_GAIN_RST     = 32'd839;
	localparam logic [GAIN_W-1:0] D_GAIN_RST     = 32'd0;
	localparam logic [OUT_W-1:0]  MAX_OUTPUT_RST = 15'd5888;

	typedef enum logic [1:0] {
		REG_P_GAIN     = 2'd0,
		REG_I_GAIN     = 2'd1,
		REG_D_GAIN     = 2'd2,
		REG_MAX_OUTPUT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] p_gain;
		logic [GAIN_W-1:0] i_gain;
		logic [GAIN_W-1:0] d_gain;
		logic [OUT_W-1:0]  max_output;
	} cfg_t;

	// error combinations, signed with 8 fraction bits (Q10.8 for dp and di, Q11.8 for dd)
	typedef struct packed {
		logic signed [17:0] dp;
		logic signed [17:0] di;
		logic signed [18:0] dd;
	} diff_t;

	typedef struct packed {
		logic [OUT_W-1:0] drive;
		logic             clamped_high;
		logic             clamped_low;
	} result_t;

endpackage

`default_nettype wire

### hdl/pidc_fifo.sv
// Small register queue with registered storage and a fill count.
`default_nettype none

module pidc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  empty,
	output logic      [CW-1:0]    count
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count not decremented on transfer out");

endmodule

`default_nettype wire

### hdl/pidc_front.sv
// Front end: takes samples, forms the error and its three combinations.
`default_nettype none

module pidc_front
	import pidc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic signed [15:0] setpoint,
	input  wire logic signed [15:0] measured_speed,
	output diff_t                   diff
);

	logic signed [16:0] e1_q;
	logic signed [16:0] e2_q;
	logic signed [16:0] err;

	assign err     = {setpoint[15], setpoint} - {measured_speed[15], measured_speed};
	assign diff.dp = {err[16], err} - {e1_q[16], e1_q};
	assign diff.di = {err[16], err} + {e1_q[16], e1_q};
	assign diff.dd = {{2{err[16]}}, err} - {e1_q[16], e1_q, 1'b0}
		+ {{2{e2_q[16]}}, e2_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q <= '0;
			e2_q <= '0;
		end else if (accept) begin
			e1_q <= err;
			e2_q <= e1_q;
		end
	end

endmodule

`default_nettype wire

### hdl/pidc_back.sv
// Back end: gain multiplies, accumulator update with saturation, output clamp.
`default_nettype none

module pidc_back
	import pidc_pkg::*;
#(
	parameter int DEPTH = 4,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cfg_t          cfg,
	input  wire logic          diff_empty,
	input  wire diff_t         diff_rdata,
	output logic               diff_pop,
	input  wire logic [CW-1:0] res_count,
	output logic               res_push,
	output result_t            res_wdata
);

	logic                     valid_s1;
	logic                     valid_s2;
	logic signed [42:0]       term_p_s1;
	logic signed [42:0]       term_i_s1;
	logic signed [43:0]       term_d_s1;
	logic signed [ACC_W-1:0]  acc_q;

	logic signed [32:0]       gain_p;
	logic signed [32:0]       gain_i;
	logic signed [32:0]       gain_d;
	logic signed [50:0]       prod_p;
	logic signed [50:0]       prod_i;
	logic signed [51:0]       prod_d;
	logic signed [SUM_W-1:0]  sum;
	logic signed [ACC_W-1:0]  acc_next;
	logic signed [ACC_W-1:0]  hi_lim;
	logic [CW+1:0]            committed;

	// results in flight plus queued must leave room for one more
	assign committed = (CW+2)'(res_count) + (CW+2)'(valid_s1) + (CW+2)'(valid_s2);
	assign diff_pop  = !diff_empty && (committed < (CW+2)'(DEPTH));

	assign gain_p = {1'b0, cfg.p_gain};
	assign gain_i = {1'b0, cfg.i_gain};
	assign gain_d = {1'b0, cfg.d_gain};
	assign prod_p = diff_rdata.dp * gain_p;
	assign prod_i = diff_rdata.di * gain_i;
	assign prod_d = diff_rdata.dd * gain_d;

	assign sum = SUM_W'(acc_q) + SUM_W'(term_p_s1) + SUM_W'(term_i_s1) + SUM_W'(term_d_s1);

	always_comb begin
		if (sum[SUM_W-1:ACC_W-1] == '0 || sum[SUM_W-1:ACC_W-1] == '1) begin
			acc_next = sum[ACC_W-1:0];
		end else begin
			acc_next = {sum[SUM_W-1], {(ACC_W-1){!sum[SUM_W-1]}}};
		end
	end

	always_ff @(posedge clk) begin
		if (diff_pop) begin
			term_p_s1 <= prod_p[50:8];
			term_i_s1 <= prod_i[50:8];
			term_d_s1 <= prod_d[51:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			acc_q    <= '0;
		end else begin
			valid_s1 <= diff_pop;
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				acc_q <= acc_next;
			end
		end
	end

	assign hi_lim   = {17'd0, cfg.max_output, 16'd0};
	assign res_push = valid_s2;

	always_comb begin
		res_wdata.clamped_high = 1'b0;
		res_wdata.clamped_low  = 1'b0;
		res_wdata.drive        = acc_q[30:16];
		if (acc_q > hi_lim) begin
			res_wdata.clamped_high = 1'b1;
			res_wdata.drive        = cfg.max_output;
		end else if (acc_q[ACC_W-1]) begin
			res_wdata.clamped_low = 1'b1;
			res_wdata.drive       = '0;
		end
	end

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		committed <= (CW+2)'(DEPTH))
		else $error("result queue overcommitted");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		diff_pop |-> !diff_empty)
		else $error("pop from empty error queue");

	a_stage_flow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> valid_s2)
		else $error("product stage lost its item");

endmodule

`default_nettype wire

### hdl/incremental_pid_speed_controller.sv
// Top level: velocity-form PID speed controller with queue-style ports.
// A sample passes through the error queue, the product stage, the accumulator stage and the result queue.
// Throughput: one sample per cycle while the result queue has room for it.
// Front and back are decoupled by a QUEUE_DEPTH error queue; results wait in a result queue.
// Reset (async, active low) restores register defaults and clears errors, accumulator, queues.
`default_nettype none

module incremental_pid_speed_controller
	import pidc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_wdata,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [15:0] setpoint,
	input  wire logic signed [15:0] measured_speed,
	input  wire logic               pop,
	output logic                    empty,
	output logic [14:0]             drive,
	output logic                    clamped_high,
	output logic                    clamped_low
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cfg_t             cfg_q;
	diff_t            diff_in;
	diff_t            diff_out;
	result_t          res_in;
	result_t          res_out;
	logic             accept;
	logic             diff_empty;
	logic             diff_pop;
	logic [CW-1:0]    diff_count;
	logic             res_push;
	logic             res_full;
	logic [CW-1:0]    res_count;
	logic [$bits(diff_t)-1:0]   diff_rd_bits;
	logic [$bits(result_t)-1:0] res_rd_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.p_gain     <= P_GAIN_RST;
			cfg_q.i_gain     <= I_GAIN_RST;
			cfg_q.d_gain     <= D_GAIN_RST;
			cfg_q.max_output <= MAX_OUTPUT_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_P_GAIN:     cfg_q.p_gain     <= cfg_wdata;
				REG_I_GAIN:     cfg_q.i_gain     <= cfg_wdata;
				REG_D_GAIN:     cfg_q.d_gain     <= cfg_wdata;
				REG_MAX_OUTPUT: cfg_q.max_output <= cfg_wdata[OUT_W-1:0];
			endcase
		end
	end

	assign accept = push && !full;

	pidc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.setpoint       (setpoint),
		.measured_speed (measured_speed),
		.diff           (diff_in)
	);

	pidc_fifo #(
		.WIDTH ($bits(diff_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_diff_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (diff_in),
		.pop    (diff_pop),
		.rdata  (diff_rd_bits),
		.full   (full),
		.empty  (diff_empty),
		.count  (diff_count)
	);

	assign diff_out = diff_t'(diff_rd_bits);

	pidc_back #(
		.DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.diff_empty (diff_empty),
		.diff_rdata (diff_out),
		.diff_pop   (diff_pop),
		.res_count  (res_count),
		.res_push   (res_push),
		.res_wdata  (res_in)
	);

	pidc_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.pop    (pop),
		.rdata  (res_rd_bits),
		.full   (res_full),
		.empty  (empty),
		.count  (res_count)
	);

	assign res_out      = result_t'(res_rd_bits);
	assign drive        = res_out.drive;
	assign clamped_high = res_out.clamped_high;
	assign clamped_low  = res_out.clamped_low;

	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result transfer into full queue");

	a_diff_count: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (diff_count == CW'(QUEUE_DEPTH)))
		else $error("full without a full error queue");

endmodule

`default_nettype wire
